FILE: hdl/assert_macros.svh
// assertion macros for the rtl of the camera follower
// no dependencies; define ASSERT_OFF to compile the checks out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked while out of reset
`ifndef ASSERT_OFF
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`endif

// next-cycle implication, checked while out of reset
`ifndef ASSERT_OFF
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: hdl/sfvt_pkg.sv
// types, codes and microcode rom of the spring follower / view transform
// no dependencies
package sfvt_pkg;

    // item kinds
    localparam logic [1:0] KIND_SET    = 2'd0;
    localparam logic [1:0] KIND_TICK   = 2'd1;
    localparam logic [1:0] KIND_VERTEX = 2'd2;

    // result kinds
    localparam logic RES_KIND_POS    = 1'b0;
    localparam logic RES_KIND_VERTEX = 1'b1;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPRING_ENABLE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPRING_CONSTANT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DAMPING         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ZOOM_SCALE      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_COS         = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_SIN         = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_WIDTH      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_HEIGHT     = 3'd7;
    localparam int CFG_DATA_W = 24;

    // register reset values
    localparam logic [23:0] RST_SPRING_CONSTANT = 24'd3276800;
    localparam logic [23:0] RST_DAMPING         = 24'd926819;
    localparam logic [23:0] RST_ZOOM_SCALE      = 24'd65536;
    localparam logic [17:0] RST_DIR_COS         = 18'd65536;

    localparam int FRAC_BITS = 16;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] in_x;
        logic signed [31:0] in_y;
        logic [15:0]        time_step;
    } item_t;

    typedef struct packed {
        logic               result_kind;
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
    } result_t;

    typedef enum logic {
        SEQ_IDLE,
        SEQ_RUN
    } seq_state_t;

    // multiplier operand a sources
    typedef enum logic [3:0] {
        A_ZERO, A_POS_X, A_POS_Y, A_VEL_X, A_VEL_Y,
        A_IDEAL_X, A_IDEAL_Y, A_IN_X, A_IN_Y, A_T0, A_T1
    } a_sel_t;

    // multiplier operand b sources
    typedef enum logic [2:0] {
        B_ZERO, B_K, B_C, B_ZOOM, B_COS, B_SIN, B_DT, B_ONE
    } b_sel_t;

    // accumulator operation on the registered product
    typedef enum logic [2:0] {
        ACC_HOLD, ACC_LOAD, ACC_LOADN, ACC_ADD, ACC_SUB
    } acc_op_t;

    // writeback of the accumulator scaled back to q16.16
    typedef enum logic [3:0] {
        WB_NONE, WB_T0, WB_T1, WB_VEL_X, WB_VEL_Y,
        WB_POS_X, WB_POS_Y, WB_RES_X, WB_RES_Y
    } wb_dst_t;

    typedef enum logic [1:0] {
        EMIT_NONE, EMIT_POS, EMIT_RES
    } emit_t;

    typedef enum logic [1:0] {
        JMP_NEXT, JMP_IF_VERT, JMP_IF_SNAP, JMP_END
    } jmp_t;

    localparam int PROG_LEN = 40;
    localparam int PC_W     = $clog2(PROG_LEN);

    localparam logic [PC_W-1:0] SNAP_ENTRY = PC_W'(23);
    localparam logic [PC_W-1:0] VERT_ENTRY = PC_W'(28);

    typedef struct packed {
        a_sel_t          a_sel;
        b_sel_t          b_sel;
        acc_op_t         acc_op;
        wb_dst_t         wb_dst;
        emit_t           emit;
        jmp_t            jmp;
        logic [PC_W-1:0] target;
    } ucode_t;

    function automatic ucode_t uw(input a_sel_t a, input b_sel_t b, input acc_op_t acc,
                                  input wb_dst_t wb, input emit_t em, input jmp_t j,
                                  input logic [PC_W-1:0] tgt);
        ucode_t w;
        w.a_sel  = a;
        w.b_sel  = b;
        w.acc_op = acc;
        w.wb_dst = wb;
        w.emit   = em;
        w.jmp    = j;
        w.target = tgt;
        return w;
    endfunction

    // the program: a product issued at step n is accumulated at step n+1,
    // and the accumulator is written back at step n+2 or later
    function automatic ucode_t ucode_word(input logic [PC_W-1:0] pc);
        localparam logic [PC_W-1:0] Z = '0;
        ucode_t w;
        unique case (pc)
            // dispatch
            PC_W'(0):  w = uw(A_ZERO, B_ZERO, ACC_HOLD, WB_NONE, EMIT_NONE, JMP_IF_VERT,
                              VERT_ENTRY);
            PC_W'(1):  w = uw(A_ZERO, B_ZERO, ACC_HOLD, WB_NONE, EMIT_NONE, JMP_IF_SNAP,
                              SNAP_ENTRY);
            // spring step, x axis
            PC_W'(2):  w = uw(A_POS_X, B_K, ACC_HOLD, WB_NONE, EMIT_NONE, JMP_NEXT, Z);
            PC_W'(3):  w = uw(A_IDEAL_X, B_K, ACC_LOADN, WB_NONE, EMIT_NONE, JMP_NEXT, Z);
            PC_W'(4):  w = uw(A_VEL_X, B_C, ACC_ADD, WB_NONE, EMIT_NONE, JMP_NEXT, Z);
            PC_W'(5):  w = uw(A_VEL_X, B_ONE, ACC_SUB, WB_NONE, EMIT_NONE, JMP_NEXT, Z);
            PC_W'(6):  w = uw(A_ZERO, B_ZERO, ACC_LOAD, WB_T0, EMIT_NONE, JMP_NEXT, Z);
            PC_W'(7):  w = uw(A_T0, B_DT, ACC_HOLD, WB_NONE, EMIT_NONE, JMP_NEXT, Z);
            PC_W'(8):  w = uw(A_POS_X, B_ONE, ACC_ADD, WB_NONE, EMIT_NONE, JMP_NEXT, Z);
            PC_W'(9):  w = uw(A_ZERO, B_ZERO, ACC_LOAD, WB_VEL_X, EMIT_NONE, JMP_NEXT, Z);
            PC_W'(10): w = uw(A_VEL_X, B_DT, ACC_HOLD, WB_NONE, EMIT_NONE, JMP_NEXT, Z);
            // x tail overlaps the y head
            PC_W'(11): w = uw(A_POS_Y, B_K, ACC_ADD, WB_NONE, EMIT_NONE, JMP_NEXT, Z);
            PC_W'(12): w = uw(A_IDEAL_Y, B_K, ACC_LOADN, WB_POS_X, EMIT_NONE, JMP_NEXT, Z);
            PC_W'(13): w = uw(A_VEL_Y, B_C, ACC_ADD, WB_NONE, EMIT_NONE, JMP_NEXT, Z);
            PC_W'(14): w = uw(A_VEL_Y, B_ONE, ACC_SUB, WB_NONE, EMIT_NONE, JMP_NEXT, Z);
            PC_W'(15): w = uw(A_ZERO, B_ZERO, ACC_LOAD, WB_T0, EMIT_NONE, JMP_NEXT, Z);
            PC_W'(16): w = uw(A_T0, B_DT, ACC_HOLD, WB_NONE, EMIT_NONE, JMP_NEXT, Z);
            PC_W'(17): w = uw(A_POS_Y, B_ONE, ACC_ADD, WB_NONE, EMIT_NONE, JMP_NEXT, Z);
            PC_W'(18): w = uw(A_ZERO, B_ZERO, ACC_LOAD, WB_VEL_Y, EMIT_NONE, JMP_NEXT, Z);
            PC_W'(19): w = uw(A_VEL_Y, B_DT, ACC_HOLD, WB_NONE, EMIT_NONE, JMP_NEXT, Z);
            PC_W'(20): w = uw(A_ZERO, B_ZERO, ACC_ADD, WB_NONE, EMIT_NONE, JMP_NEXT, Z);
            PC_W'(21): w = uw(A_ZERO, B_ZERO, ACC_HOLD, WB_POS_Y, EMIT_NONE, JMP_NEXT, Z);
            PC_W'(22): w = uw(A_ZERO, B_ZERO, ACC_HOLD, WB_NONE, EMIT_POS, JMP_END, Z);
            // snap to ideal
            PC_W'(23): w = uw(A_IDEAL_X, B_ONE, ACC_HOLD, WB_NONE, EMIT_NONE, JMP_NEXT, Z);
            PC_W'(24): w = uw(A_IDEAL_Y, B_ONE, ACC_LOAD, WB_NONE, EMIT_NONE, JMP_NEXT, Z);
            PC_W'(25): w = uw(A_ZERO, B_ZERO, ACC_LOAD, WB_POS_X, EMIT_NONE, JMP_NEXT, Z);
            PC_W'(26): w = uw(A_ZERO, B_ZERO, ACC_HOLD, WB_POS_Y, EMIT_NONE, JMP_NEXT, Z);
            PC_W'(27): w = uw(A_ZERO, B_ZERO, ACC_HOLD, WB_NONE, EMIT_POS, JMP_END, Z);
            // vertex transform
            PC_W'(28): w = uw(A_IN_X, B_ZOOM, ACC_HOLD, WB_NONE, EMIT_NONE, JMP_NEXT, Z);
            PC_W'(29): w = uw(A_POS_X, B_ZOOM, ACC_LOAD, WB_NONE, EMIT_NONE, JMP_NEXT, Z);
            PC_W'(30): w = uw(A_IN_Y, B_ZOOM, ACC_SUB, WB_NONE, EMIT_NONE, JMP_NEXT, Z);
            PC_W'(31): w = uw(A_POS_Y, B_ZOOM, ACC_LOAD, WB_T0, EMIT_NONE, JMP_NEXT, Z);
            PC_W'(32): w = uw(A_ZERO, B_ZERO, ACC_SUB, WB_NONE, EMIT_NONE, JMP_NEXT, Z);
            PC_W'(33): w = uw(A_T0, B_COS, ACC_HOLD, WB_T1, EMIT_NONE, JMP_NEXT, Z);
            PC_W'(34): w = uw(A_T1, B_SIN, ACC_LOAD, WB_NONE, EMIT_NONE, JMP_NEXT, Z);
            PC_W'(35): w = uw(A_T1, B_COS, ACC_ADD, WB_NONE, EMIT_NONE, JMP_NEXT, Z);
            PC_W'(36): w = uw(A_T0, B_SIN, ACC_LOAD, WB_RES_X, EMIT_NONE, JMP_NEXT, Z);
            PC_W'(37): w = uw(A_ZERO, B_ZERO, ACC_SUB, WB_NONE, EMIT_NONE, JMP_NEXT, Z);
            PC_W'(38): w = uw(A_ZERO, B_ZERO, ACC_HOLD, WB_RES_Y, EMIT_NONE, JMP_NEXT, Z);
            PC_W'(39): w = uw(A_ZERO, B_ZERO, ACC_HOLD, WB_NONE, EMIT_RES, JMP_END, Z);
            default:   w = uw(A_ZERO, B_ZERO, ACC_HOLD, WB_NONE, EMIT_NONE, JMP_END, Z);
        endcase
        return w;
    endfunction

    // clamp to signed 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
        logic signed [31:0] r;
        if (v > 49'sh0_0000_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -49'sh0_0000_8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

FILE: hdl/spring_follow_view_transform_top.sv
// top level of the 2d camera spring follower and view transform
// depends on sfvt_pkg and assert_macros.svh
//
// 2d camera block. set transactions store the ideal position.
// tick transactions run a spring-damper step (or snap to the ideal position
// when the spring is disabled) and return the camera position; vertex
// transactions return the point moved by -pos, scaled, rotated by the
// conjugate of (dir_cos, dir_sin) and offset by the half screen size, all
// q16.16 and saturated. one item is worked on at a time. the work is run by
// a microcode program over one shared 43x25 multiplier feeding a 64-bit
// accumulator, one control word per cycle while no emit step stalls;
// item_ready is high only between programs. a result waits in an output
// register and the program stalls at its emit step only while that
// register is full. configuration writes are always taken and are meant
// to land while idle.

module spring_follow_view_transform_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_ready,
    input  sfvt_pkg::item_t                     item,
    output logic                                result_valid,
    input  logic                                result_ready,
    output sfvt_pkg::result_t                   result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sfvt_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sfvt_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import sfvt_pkg::*;

    `include "assert_macros.svh"

    // configuration registers
    logic               spring_enable_reg;
    logic [23:0]        spring_constant_reg;
    logic [23:0]        damping_reg;
    logic [23:0]        zoom_reg;
    logic signed [17:0] dir_cos_reg;
    logic signed [17:0] dir_sin_reg;
    logic [11:0]        half_width_reg;
    logic [11:0]        half_height_reg;

    // camera state
    logic signed [31:0] pos_x_reg, pos_y_reg;
    logic signed [31:0] vel_x_reg, vel_y_reg;
    logic signed [31:0] ideal_x_reg, ideal_y_reg;

    // latched item and scratch
    item_t              item_reg;
    logic signed [42:0] t0_reg, t1_reg;
    logic signed [31:0] res_x_reg, res_y_reg;
    logic signed [63:0] prod_reg;
    logic signed [63:0] acc_reg;
    logic signed [63:0] acc_next;

    // sequencer
    seq_state_t         state_reg, state_next;
    logic [PC_W-1:0]    pc_reg, pc_next;
    ucode_t             word;
    logic               advance;

    // output register
    logic               out_valid_reg;
    result_t            out_reg;
    logic               out_load;

    logic               item_fire;
    logic               start_prog;

    logic signed [42:0] opa;
    logic signed [24:0] opb;
    logic signed [67:0] prod_full;
    logic signed [63:0] acc_shr;
    logic signed [47:0] wb_base;
    logic [27:0]        wb_offset;
    logic signed [48:0] wb_sum;
    logic signed [31:0] wb_sat;

    assign cfg_ready    = 1'b1;
    assign item_ready   = (state_reg == SEQ_IDLE);
    assign item_fire    = item_valid && item_ready;
    assign start_prog   = item_fire && ((item.kind == KIND_TICK) || (item.kind == KIND_VERTEX));

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // current control word; idle reads word zero but nothing acts on it
    assign word = ucode_word(pc_reg);

    // only an emit step waits, and only on a full output register
    assign advance  = !((word.emit != EMIT_NONE) && out_valid_reg && !result_ready);
    assign out_load = (state_reg == SEQ_RUN) && (word.emit != EMIT_NONE) && advance;

    // ---------------- sequencer next state ----------------
    always_comb begin
        state_next = state_reg;
        pc_next    = pc_reg;
        unique case (state_reg)
            SEQ_IDLE:
            begin
                if (start_prog) begin
                    state_next = SEQ_RUN;
                    pc_next    = '0;
                end
            end
            SEQ_RUN:
            begin
                if (advance) begin
                    unique case (word.jmp)
                        JMP_NEXT:    pc_next = pc_reg + 1'b1;
                        JMP_IF_VERT: pc_next = (item_reg.kind == KIND_VERTEX) ?
                                               word.target : pc_reg + 1'b1;
                        JMP_IF_SNAP: pc_next = !spring_enable_reg ?
                                               word.target : pc_reg + 1'b1;
                        JMP_END:
                        begin
                            state_next = SEQ_IDLE;
                            pc_next    = '0;
                        end
                    endcase
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= SEQ_IDLE;
            pc_reg    <= '0;
        end else begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
        end
    end

    // ---------------- datapath controls ----------------
    // operand a, sign extended to the multiplier width
    always_comb begin
        unique case (word.a_sel)
            A_POS_X:   opa = 43'(pos_x_reg);
            A_POS_Y:   opa = 43'(pos_y_reg);
            A_VEL_X:   opa = 43'(vel_x_reg);
            A_VEL_Y:   opa = 43'(vel_y_reg);
            A_IDEAL_X: opa = 43'(ideal_x_reg);
            A_IDEAL_Y: opa = 43'(ideal_y_reg);
            A_IN_X:    opa = 43'(item_reg.in_x);
            A_IN_Y:    opa = 43'(item_reg.in_y);
            A_T0:      opa = t0_reg;
            A_T1:      opa = t1_reg;
            default:   opa = '0;
        endcase
    end

    // operand b; unsigned registers get a zero sign bit
    always_comb begin
        unique case (word.b_sel)
            B_K:     opb = $signed({1'b0, spring_constant_reg});
            B_C:     opb = $signed({1'b0, damping_reg});
            B_ZOOM:  opb = $signed({1'b0, zoom_reg});
            B_COS:   opb = 25'(dir_cos_reg);
            B_SIN:   opb = 25'(dir_sin_reg);
            B_DT:    opb = $signed({9'b0, item_reg.time_step});
            B_ONE:   opb = 25'sd1 <<< FRAC_BITS;
            default: opb = '0;
        endcase
    end

    // products stay below 2^60 in magnitude, so 64 bits hold them exactly
    assign prod_full = opa * opb;

    always_comb begin
        unique case (word.acc_op)
            ACC_LOAD:  acc_next = prod_reg;
            ACC_LOADN: acc_next = -prod_reg;
            ACC_ADD:   acc_next = acc_reg + prod_reg;
            ACC_SUB:   acc_next = acc_reg - prod_reg;
            default:   acc_next = acc_reg;
        endcase
    end

    // writeback: arithmetic shift is the floor, then screen offset and clamp
    assign acc_shr = acc_reg >>> FRAC_BITS;
    assign wb_base = acc_shr[47:0];

    always_comb begin
        unique case (word.wb_dst)
            WB_RES_X: wb_offset = {half_width_reg, 16'b0};
            WB_RES_Y: wb_offset = {half_height_reg, 16'b0};
            default:  wb_offset = '0;
        endcase
    end

    assign wb_sum = 49'(wb_base) + $signed({21'b0, wb_offset});
    assign wb_sat = sat32(wb_sum);

    // ---------------- datapath registers ----------------
    always_ff @(posedge clk) begin
        if (item_fire) begin
            item_reg <= item;
        end
        if (state_reg == SEQ_RUN) begin
            prod_reg <= prod_full[63:0];
            acc_reg  <= acc_next;
            unique case (word.wb_dst)
                WB_T0:    t0_reg    <= wb_base[42:0];
                WB_T1:    t1_reg    <= wb_base[42:0];
                WB_RES_X: res_x_reg <= wb_sat;
                WB_RES_Y: res_y_reg <= wb_sat;
                default:  ;
            endcase
        end
    end

    // camera state: reset to zero, written by set transactions and the program
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            pos_x_reg   <= '0;
            pos_y_reg   <= '0;
            vel_x_reg   <= '0;
            vel_y_reg   <= '0;
            ideal_x_reg <= '0;
            ideal_y_reg <= '0;
        end else begin
            if (item_fire && (item.kind == KIND_SET)) begin
                ideal_x_reg <= item.in_x;
                ideal_y_reg <= item.in_y;
            end
            if (state_reg == SEQ_RUN) begin
                unique case (word.wb_dst)
                    WB_VEL_X: vel_x_reg <= wb_sat;
                    WB_VEL_Y: vel_y_reg <= wb_sat;
                    WB_POS_X: pos_x_reg <= wb_sat;
                    WB_POS_Y: pos_y_reg <= wb_sat;
                    default:  ;
                endcase
            end
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            spring_enable_reg   <= 1'b1;
            spring_constant_reg <= RST_SPRING_CONSTANT;
            damping_reg         <= RST_DAMPING;
            zoom_reg            <= RST_ZOOM_SCALE;
            dir_cos_reg         <= RST_DIR_COS;
            dir_sin_reg         <= '0;
            half_width_reg      <= '0;
            half_height_reg     <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_SPRING_ENABLE:   spring_enable_reg   <= cfg_data[0];
                CFG_SPRING_CONSTANT: spring_constant_reg <= cfg_data;
                CFG_DAMPING:         damping_reg         <= cfg_data;
                CFG_ZOOM_SCALE:      zoom_reg            <= cfg_data;
                CFG_DIR_COS:         dir_cos_reg         <= cfg_data[17:0];
                CFG_DIR_SIN:         dir_sin_reg         <= cfg_data[17:0];
                CFG_HALF_WIDTH:      half_width_reg      <= cfg_data[11:0];
                CFG_HALF_HEIGHT:     half_height_reg     <= cfg_data[11:0];
            endcase
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_load || (out_valid_reg && !result_ready);
        end
    end

    always_ff @(posedge clk) begin
        if (out_load) begin
            if (word.emit == EMIT_RES) begin
                out_reg.result_kind <= RES_KIND_VERTEX;
                out_reg.out_x       <= res_x_reg;
                out_reg.out_y       <= res_y_reg;
            end else begin
                out_reg.result_kind <= RES_KIND_POS;
                out_reg.out_x       <= pos_x_reg;
                out_reg.out_y       <= pos_y_reg;
            end
        end
    end

    // ---------------- assertions ----------------
    `ASSERT_NEXT(a_stall_holds_pc, clk, rst_n, (state_reg == SEQ_RUN) && !advance,
                 (state_reg == SEQ_RUN) && $stable(pc_reg), "emit stall moved the program")
    `ASSERT_IMPL(a_pc_in_program, clk, rst_n, state_reg == SEQ_RUN,
                 pc_reg < PC_W'(PROG_LEN), "program counter left the program")
    `ASSERT_NEXT(a_item_starts_program, clk, rst_n, start_prog,
                 (state_reg == SEQ_RUN) && (pc_reg == '0), "tick or vertex did not start")

endmodule

FILE: tb/sfvt_tb_pkg.sv
// checker for the spring follower / view transform testbench
// holds a copy of the camera state and registers and the queue of pending results
// depends on sfvt_pkg
package sfvt_tb_pkg;

    timeunit 1ns;
    timeprecision 1ps;

    import sfvt_pkg::*;

    // kind code the block ignores
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    class camera_follow_checker;

        // register copy
        bit     spring_on;
        longint stiffness;
        longint damping;
        longint zoom;
        longint dir_c;
        longint dir_s;
        longint half_w;
        longint half_h;

        // camera state, q16.16
        int pos_x;
        int pos_y;
        int vel_x;
        int vel_y;
        int goal_x;
        int goal_y;

        result_t pending_results[$];
        int      errors;

        function new();
            set_reg(CFG_SPRING_ENABLE, 24'd1);
            set_reg(CFG_SPRING_CONSTANT, RST_SPRING_CONSTANT);
            set_reg(CFG_DAMPING, RST_DAMPING);
            set_reg(CFG_ZOOM_SCALE, RST_ZOOM_SCALE);
            set_reg(CFG_DIR_COS, {6'd0, RST_DIR_COS});
            set_reg(CFG_DIR_SIN, 24'd0);
            set_reg(CFG_HALF_WIDTH, 24'd0);
            set_reg(CFG_HALF_HEIGHT, 24'd0);
            pos_x  = 0;
            pos_y  = 0;
            vel_x  = 0;
            vel_y  = 0;
            goal_x = 0;
            goal_y = 0;
            errors = 0;
        endfunction

        function void set_reg(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] data);
            logic signed [17:0] dir_val;
            dir_val = data[17:0];
            case (idx)
                CFG_SPRING_ENABLE:   spring_on = data[0];
                CFG_SPRING_CONSTANT: stiffness = longint'({40'd0, data});
                CFG_DAMPING:         damping   = longint'({40'd0, data});
                CFG_ZOOM_SCALE:      zoom      = longint'({40'd0, data});
                CFG_DIR_COS:         dir_c     = dir_val;
                CFG_DIR_SIN:         dir_s     = dir_val;
                CFG_HALF_WIDTH:      half_w    = longint'({52'd0, data[11:0]});
                CFG_HALF_HEIGHT:     half_h    = longint'({52'd0, data[11:0]});
                default: ;
            endcase
        endfunction

        static function int saturate_q16(input longint v);
            if (v > longint'(32'sh7FFF_FFFF)) begin
                return 32'sh7FFF_FFFF;
            end
            if (v < -longint'(64'sh8000_0000)) begin
                return 32'sh8000_0000;
            end
            return int'(v);
        endfunction

        // one spring-damper step on one axis
        function void spring_axis(inout int pos, inout int vel, input int goal,
                                  input longint dt);
            longint disp;
            longint accel;
            int     new_vel;
            disp    = longint'(pos) - longint'(goal);
            accel   = (-(stiffness * disp) - damping * longint'(vel)) >>> FRAC_BITS;
            new_vel = saturate_q16(longint'(vel) + ((accel * dt) >>> FRAC_BITS));
            vel     = new_vel;
            pos     = saturate_q16(longint'(pos) + ((longint'(new_vel) * dt) >>> FRAC_BITS));
        endfunction

        function void note_item(input item_t it);
            int      ix;
            int      iy;
            longint  dt;
            longint  sx;
            longint  sy;
            longint  rx;
            longint  ry;
            result_t r;
            ix = it.in_x;
            iy = it.in_y;
            dt = longint'({48'd0, it.time_step});
            case (it.kind)
                KIND_SET: begin
                    goal_x = ix;
                    goal_y = iy;
                end
                KIND_TICK: begin
                    if (spring_on) begin
                        spring_axis(pos_x, vel_x, goal_x, dt);
                        spring_axis(pos_y, vel_y, goal_y, dt);
                    end else begin
                        pos_x = goal_x;
                        pos_y = goal_y;
                    end
                    r.result_kind = RES_KIND_POS;
                    r.out_x       = pos_x;
                    r.out_y       = pos_y;
                    pending_results = {pending_results, r};
                end
                KIND_VERTEX: begin
                    sx = ((longint'(ix) - longint'(pos_x)) * zoom) >>> FRAC_BITS;
                    sy = ((longint'(iy) - longint'(pos_y)) * zoom) >>> FRAC_BITS;
                    rx = ((sx * dir_c + sy * dir_s) >>> FRAC_BITS) + (half_w <<< FRAC_BITS);
                    ry = ((sy * dir_c - sx * dir_s) >>> FRAC_BITS) + (half_h <<< FRAC_BITS);
                    r.result_kind = RES_KIND_VERTEX;
                    r.out_x       = saturate_q16(rx);
                    r.out_y       = saturate_q16(ry);
                    pending_results = {pending_results, r};
                end
                default: ;
            endcase
        endfunction

        function void compare_field(input string name, input logic [31:0] want,
                                    input logic [31:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t ns: %s mismatch, expected %h actual %h", $time, name,
                         want, got);
            end
        endfunction

        function void check_result(input result_t got);
            result_t want;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t ns: result with none pending, expected nothing actual %h",
                         $time, got);
                return;
            end
            want = pending_results.pop_front();
            compare_field("result_kind", {31'd0, want.result_kind}, {31'd0, got.result_kind});
            compare_field("out_x", want.out_x, got.out_x);
            compare_field("out_y", want.out_y, got.out_y);
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

    endclass

endpackage

FILE: tb/tb_spring_follow_view_transform_top.sv
// testbench top for spring_follow_view_transform_top
// drives set, tick and vertex transactions plus register writes, checks every result
// depends on sfvt_pkg, sfvt_tb_pkg and the rtl of the block
module tb_spring_follow_view_transform_top;

    timeunit 1ns;
    timeprecision 1ps;

    import sfvt_pkg::*;
    import sfvt_tb_pkg::*;

    // run bounds
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 40;    // longest program is the spring tick
    localparam int BLOCKS        = 9;
    localparam int BLOCK_ITEMS   = 190;
    localparam int HOLD_CYCLES   = 600;

    logic                   clk;
    logic                   rst_n;
    logic                   item_valid;
    logic                   item_ready;
    item_t                  item;
    logic                   result_valid;
    logic                   result_ready;
    result_t                result;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    camera_follow_checker camera_model;

    // idle percentages of the two sides and the long receiver hold-off
    int send_idle_pct;
    int recv_idle_pct;
    int hold_left;
    int cycle_count;

    spring_follow_view_transform_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // 4 ns clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // watchdog on the cycle count
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // receiver: random stalls, or a long hold-off while hold_left runs down
    initial
    begin
        result_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else
            begin
                result_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // monitor: every accepted transaction goes to the checker, sampled at the edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                camera_model.check_result(result);
            end
            if (item_valid && item_ready)
            begin
                camera_model.note_item(item);
            end
            if (cfg_valid && cfg_ready)
            begin
                camera_model.set_reg(cfg_index, cfg_data);
            end
        end
    end

    function automatic item_t make_item(input logic [1:0] kind, input logic [31:0] x,
                                        input logic [31:0] y, input logic [15:0] dt);
        item_t it;
        it.kind      = kind;
        it.in_x      = x;
        it.in_y      = y;
        it.time_step = dt;
        return it;
    endfunction

    // mostly screen-sized coordinates, some full range and some extremes
    function automatic logic [31:0] rand_coord();
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0: v = $urandom;
            1:
            begin
                case ($urandom_range(0, 3))
                    0:       v = 32'h7FFF_FFFF;
                    1:       v = 32'h8000_0000;
                    2:       v = '0;
                    default: v = '1;
                endcase
            end
            default:
            begin
                v = $urandom_range(0, 32'h0800_0000);
                if ($urandom_range(0, 1) == 1)
                begin
                    v = -v;
                end
            end
        endcase
        return v;
    endfunction

    // mostly frame-length steps, with zero, full and random steps mixed in
    function automatic logic [15:0] rand_step();
        logic [15:0] dt;
        case ($urandom_range(0, 9))
            0:       dt = '0;
            1:       dt = '1;
            2:       dt = 16'($urandom);
            default: dt = 16'($urandom_range(400, 4400));
        endcase
        return dt;
    endfunction

    function automatic item_t rand_item();
        int         pick;
        logic [1:0] kind;
        pick = $urandom_range(0, 99);
        if (pick < 24)
        begin
            kind = KIND_SET;
        end
        else if (pick < 60)
        begin
            kind = KIND_TICK;
        end
        else if (pick < 96)
        begin
            kind = KIND_VERTEX;
        end
        else
        begin
            kind = KIND_UNUSED;
        end
        return make_item(kind, rand_coord(), rand_coord(), rand_step());
    endfunction

    // offer one transaction and hold it until accepted; valid stays high on return
    task automatic send_item(input item_t it);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        do @(posedge clk); while (!item_ready);
    endtask

    task automatic drive_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // write all eight registers back to back
    task automatic apply_config(input logic [23:0] en, input logic [23:0] k,
                                input logic [23:0] c, input logic [23:0] z,
                                input logic [23:0] dc, input logic [23:0] ds,
                                input logic [23:0] hw, input logic [23:0] hh);
        drive_reg(CFG_SPRING_ENABLE, en);
        drive_reg(CFG_SPRING_CONSTANT, k);
        drive_reg(CFG_DAMPING, c);
        drive_reg(CFG_ZOOM_SCALE, z);
        drive_reg(CFG_DIR_COS, dc);
        drive_reg(CFG_DIR_SIN, ds);
        drive_reg(CFG_HALF_WIDTH, hw);
        drive_reg(CFG_HALF_HEIGHT, hh);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // random register set, extremes included; unused data bits carry noise
    task automatic pick_config();
        logic [31:0] noise;
        logic [23:0] k;
        logic [23:0] c;
        logic [23:0] z;
        logic [11:0] hw;
        logic [11:0] hh;
        int          dc;
        int          ds;
        real         angle;
        int          dir_extremes [5] = '{65536, -65536, 0, 131071, -131072};
        noise = $urandom;
        case ($urandom_range(0, 5))
            0:       k = '0;
            1:       k = '1;
            2:       k = 24'($urandom);
            default: k = 24'($urandom_range(32'h1_0000, 32'h78_0000));
        endcase
        // damping critical, 2*sqrt(k), half the time
        case ($urandom_range(0, 5))
            0:       c = '0;
            1:       c = '1;
            2:       c = 24'($urandom);
            default: c = 24'(int'(2.0 * $sqrt(real'(k) / 65536.0) * 65536.0));
        endcase
        case ($urandom_range(0, 5))
            0:       z = '0;
            1:       z = '1;
            2:       z = 24'($urandom);
            default: z = 24'($urandom_range(32'h4000, 32'h4_0000));
        endcase
        case ($urandom_range(0, 3))
            0:
            begin
                dc = $urandom;
                ds = $urandom;
            end
            1:
            begin
                dc = dir_extremes[$urandom_range(0, 4)];
                ds = dir_extremes[$urandom_range(0, 4)];
            end
            default:
            begin
                angle = real'($urandom_range(0, 359)) * 3.14159265358979 / 180.0;
                dc    = int'($cos(angle) * 65536.0);
                ds    = int'($sin(angle) * 65536.0);
            end
        endcase
        case ($urandom_range(0, 3))
            0:       hw = '0;
            1:       hw = '1;
            default: hw = 12'($urandom);
        endcase
        case ($urandom_range(0, 3))
            0:       hh = '0;
            1:       hh = '1;
            default: hh = 12'($urandom);
        endcase
        apply_config({noise[23:1], $urandom_range(0, 3) != 0}, k, c, z,
                     {noise[5:0], dc[17:0]}, {noise[11:6], ds[17:0]},
                     {noise[23:12], hw}, {noise[11:0], hh});
    endtask

    // drop valid, let every pending result come out, then let a trailing set finish
    task automatic wait_idle();
        item_valid <= 1'b0;
        do @(posedge clk); while (camera_model.pending() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int counted;
        item_t it;

        camera_model  = new();
        send_idle_pct = 36;
        recv_idle_pct = 84;
        hold_left     = 0;
        rst_n         = 1'b0;
        item_valid    = 1'b0;
        item          = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset register values, zero and full steps, ignored fields
        send_item(make_item(KIND_TICK, 32'h0, 32'h0, 16'h0));
        send_item(make_item(KIND_SET, 32'h0064_0000, 32'hFFCE_0000, 16'hFFFF));
        send_item(make_item(KIND_TICK, 32'hDEAD_BEEF, 32'h1234_5678, 16'd1092));
        send_item(make_item(KIND_TICK, 32'h0, 32'h0, 16'hFFFF));
        send_item(make_item(KIND_VERTEX, 32'h7FFF_FFFF, 32'h8000_0000, 16'hA5A5));
        send_item(make_item(KIND_VERTEX, 32'h0, 32'h0, 16'h0));
        send_item(make_item(KIND_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF));
        send_item(make_item(KIND_TICK, 32'h0, 32'h0, 16'd1092));
        wait_idle();

        // spring off snaps to ideal, zoom at max, cosine at minus one
        apply_config(24'hFFFFFE, 24'h0, 24'h0, 24'hFFFFFF, 24'hFF0000, 24'h000000,
                     24'h000000, 24'h000000);
        send_item(make_item(KIND_SET, 32'h7FFF_FFFF, 32'h8000_0000, 16'h0));
        send_item(make_item(KIND_TICK, 32'h0, 32'h0, 16'd1092));
        send_item(make_item(KIND_VERTEX, 32'h8000_0000, 32'h7FFF_FFFF, 16'h0));
        send_item(make_item(KIND_VERTEX, 32'h7FFF_0000, 32'h8001_0000, 16'h0));
        wait_idle();

        // stiffest spring, unnormalized direction, full half size, zero zoom
        apply_config(24'h000001, 24'hFFFFFF, 24'hFFFFFF, 24'h000000, 24'h01FFFF,
                     24'h020000, 24'hFFFFFF, 24'h000FFF);
        send_item(make_item(KIND_SET, 32'h8000_0000, 32'h7FFF_FFFF, 16'h1234));
        send_item(make_item(KIND_TICK, 32'h0, 32'h0, 16'hFFFF));
        send_item(make_item(KIND_TICK, 32'h0, 32'h0, 16'hFFFF));
        send_item(make_item(KIND_VERTEX, 32'h0010_0000, 32'hFFF0_0000, 16'h0));
        send_item(make_item(KIND_UNUSED, 32'h0, 32'h0, 16'h0));
        wait_idle();

        // no spring force at all, zoom two, quarter turn, typical screen
        apply_config(24'h000001, 24'h0, 24'h0, 24'h020000, 24'hFC0000, 24'h010000,
                     24'h000140, 24'h0000F0);
        send_item(make_item(KIND_TICK, 32'h0, 32'h0, 16'd1092));
        send_item(make_item(KIND_SET, 32'h0140_0000, 32'h00F0_0000, 16'h0));
        send_item(make_item(KIND_TICK, 32'h0, 32'h0, 16'd2184));
        send_item(make_item(KIND_VERTEX, 32'h0150_8000, 32'h00E0_4000, 16'h0));
        wait_idle();

        // random blocks: sender idles 36 / receiver 84, then reversed, then no idling
        for (int blk = 0; blk < BLOCKS; blk++)
        begin
            case (blk / 3)
                0:
                begin
                    send_idle_pct = 36;
                    recv_idle_pct = 84;
                end
                1:
                begin
                    send_idle_pct = 84;
                    recv_idle_pct = 36;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            pick_config();
            // long receiver hold-off while items keep coming, fills the block
            if (blk == BLOCKS - 2)
            begin
                hold_left = HOLD_CYCLES;
            end
            counted = 0;
            while (counted < BLOCK_ITEMS)
            begin
                it = rand_item();
                send_item(it);
                if (it.kind != KIND_UNUSED)
                begin
                    counted++;
                end
            end
            wait_idle();
        end

        if (camera_model.errors == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
